// ----- sv/tpa_pkg.sv -----
// shared widths, constants and result type of the three-point texture axis solver
package tpa_pkg;

    localparam int C_IN_W        = 26;   // point coordinate
    localparam int C_E_W         = 27;   // edge vector component
    localparam int C_G_W         = 56;   // gram terms a, b, d
    localparam int C_DET_W       = 112;  // determinant
    localparam int C_SP_W        = 83;   // gram term times edge component
    localparam int C_N_W         = 84;   // axis numerators
    localparam int C_NP_W        = 110;  // axis numerator times p0 component
    localparam int C_O_W         = 112;  // offset numerators
    localparam int C_OUT_W       = 48;   // result fields
    localparam int C_THR_W       = 32;   // threshold register, all fraction bits
    localparam int C_SCALE_SHIFT = 7;    // edge scale of 1/128
    localparam int C_LIMB_W      = 32;   // multiplier limb
    localparam int C_MUL_LAT     = 4;
    localparam int C_DIV_LAT     = C_OUT_W + 4;

    localparam logic [C_THR_W-1:0] C_THR_RST = 32'd429497;

    typedef struct packed {
        logic signed [C_OUT_W-1:0] s_axis_x;
        logic signed [C_OUT_W-1:0] s_axis_y;
        logic signed [C_OUT_W-1:0] s_axis_z;
        logic signed [C_OUT_W-1:0] s_offset;
        logic signed [C_OUT_W-1:0] t_axis_x;
        logic signed [C_OUT_W-1:0] t_axis_y;
        logic signed [C_OUT_W-1:0] t_axis_z;
        logic signed [C_OUT_W-1:0] t_offset;
        logic                      degenerate;
    } t_res;

endpackage

// ----- sv/three_point_texture_axis_solve.sv -----
// top level of the three-point texture axis solver
// Takes one face (three points and an order flag) per cycle and returns its S and T texture
// axes and offsets in signed Q16.32, saturated, with a degenerate flag that zeroes all eight
// values when the gram determinant falls below det_threshold. The datapath is a single
// 69-stage pipeline: edge vectors, gram products, determinant and numerators through
// 32x32-limb multipliers of four stages each, then eight dividers that settle one quotient
// bit per stage. Sustained rate is one beat per cycle. A two-entry output queue keeps the
// pipeline moving while a result waits; the pipeline holds only when that queue is full and
// a finished beat waits at the last stage.
module three_point_texture_axis_solve import tpa_pkg::*; #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int OUT_FRAC_BITS   = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [C_THR_W-1:0]        i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_reverse_order,
    input  logic signed [C_IN_W-1:0]  i_p0_x,
    input  logic signed [C_IN_W-1:0]  i_p0_y,
    input  logic signed [C_IN_W-1:0]  i_p0_z,
    input  logic signed [C_IN_W-1:0]  i_p1_x,
    input  logic signed [C_IN_W-1:0]  i_p1_y,
    input  logic signed [C_IN_W-1:0]  i_p1_z,
    input  logic signed [C_IN_W-1:0]  i_p2_x,
    input  logic signed [C_IN_W-1:0]  i_p2_y,
    input  logic signed [C_IN_W-1:0]  i_p2_z,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [C_OUT_W-1:0] o_s_axis_x,
    output logic signed [C_OUT_W-1:0] o_s_axis_y,
    output logic signed [C_OUT_W-1:0] o_s_axis_z,
    output logic signed [C_OUT_W-1:0] o_s_offset,
    output logic signed [C_OUT_W-1:0] o_t_axis_x,
    output logic signed [C_OUT_W-1:0] o_t_axis_y,
    output logic signed [C_OUT_W-1:0] o_t_axis_z,
    output logic signed [C_OUT_W-1:0] o_t_offset,
    output logic                      o_degenerate
);

    localparam int K      = COORD_FRAC_BITS + C_SCALE_SHIFT;
    localparam int SH_AX  = K + OUT_FRAC_BITS;
    localparam int SH_OF  = C_SCALE_SHIFT + OUT_FRAC_BITS;
    localparam int THR_SH = 4 * K;
    localparam int TW     = ((C_DET_W + C_THR_W > C_THR_W + THR_SH) ?
                             C_DET_W + C_THR_W : C_THR_W + THR_SH) + 1;
    localparam int DEN_W  = C_DET_W - 1;

    localparam int ST_UW   = 1;
    localparam int ST_GRAM = ST_UW + C_MUL_LAT + 1;
    localparam int ST_PROD = ST_GRAM + C_MUL_LAT + 1;
    localparam int ST_OFS  = ST_PROD + C_MUL_LAT + 1;
    localparam int ST_LAST = ST_OFS + C_DIV_LAT;
    localparam int UW_D    = ST_GRAM - ST_UW;
    localparam int P0_D    = ST_PROD - ST_UW;
    localparam int SN_D    = ST_OFS - ST_PROD;
    localparam int DG_D    = ST_LAST - ST_PROD - 1;

    logic                      w_adv;
    logic                      w_push;
    logic                      w_pop;
    logic [C_THR_W-1:0]        r_thr;
    logic                      r_v [ST_LAST+1];

    logic                      r_rev;
    logic signed [C_IN_W-1:0]  r_p [3][3];
    logic signed [C_E_W-1:0]   n_u [3];
    logic signed [C_E_W-1:0]   n_w [3];
    logic signed [C_E_W-1:0]   r_u [3];
    logic signed [C_E_W-1:0]   r_w [3];
    logic signed [C_IN_W-1:0]  r_p0 [3];
    logic signed [C_E_W-1:0]   r_u_d [UW_D][3];
    logic signed [C_E_W-1:0]   r_w_d [UW_D][3];
    logic signed [C_IN_W-1:0]  r_p0_d [P0_D][3];

    logic signed [2*C_E_W-1:0] w_uu [3];
    logic signed [2*C_E_W-1:0] w_uw [3];
    logic signed [2*C_E_W-1:0] w_ww [3];
    logic signed [C_G_W-1:0]   r_a;
    logic signed [C_G_W-1:0]   r_b;
    logic signed [C_G_W-1:0]   r_d;

    logic signed [C_DET_W-1:0] w_ad;
    logic signed [C_DET_W-1:0] w_bb;
    logic signed [C_SP_W-1:0]  w_du [3];
    logic signed [C_SP_W-1:0]  w_bw [3];
    logic signed [C_SP_W-1:0]  w_bu [3];
    logic signed [C_SP_W-1:0]  w_aw [3];
    logic signed [C_DET_W-1:0] r_det;
    logic signed [C_N_W-1:0]   r_sn [3];
    logic signed [C_N_W-1:0]   r_tn [3];

    logic [TW-1:0]             w_lhs;
    logic [TW-1:0]             w_rhs;
    logic                      r_deg;
    logic                      r_deg_d [DG_D];

    logic signed [C_NP_W-1:0]  w_sp [3];
    logic signed [C_NP_W-1:0]  w_tp [3];
    logic signed [C_N_W-1:0]   r_sn_d [SN_D][3];
    logic signed [C_N_W-1:0]   r_tn_d [SN_D][3];
    logic signed [C_DET_W-1:0] r_det_d [SN_D];
    logic signed [C_O_W-1:0]   r_so;
    logic signed [C_O_W-1:0]   r_to;

    logic signed [C_OUT_W-1:0] w_sq [3];
    logic signed [C_OUT_W-1:0] w_tq [3];
    logic signed [C_OUT_W-1:0] w_soq;
    logic signed [C_OUT_W-1:0] w_toq;
    t_res                      n_res;
    t_res                      r_fifo [2];
    logic                      r_wptr;
    logic                      r_rptr;
    logic [1:0]                r_cnt;
    t_res                      w_head;

    // pipeline moves unless a finished beat is blocked by a full queue
    assign w_adv      = (r_cnt != 2'd2) || !r_v[ST_LAST];
    assign o_in_ready = w_adv;
    assign w_push     = w_adv && r_v[ST_LAST];
    assign w_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= C_THR_RST;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ST_LAST; i++) r_v[i] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_in_valid;
            for (int i = 1; i <= ST_LAST; i++) r_v[i] <= r_v[i-1];
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_u[j] = r_rev ? C_E_W'(r_p[1][j]) - C_E_W'(r_p[0][j])
                           : C_E_W'(r_p[2][j]) - C_E_W'(r_p[0][j]);
            n_w[j] = r_rev ? C_E_W'(r_p[2][j]) - C_E_W'(r_p[0][j])
                           : C_E_W'(r_p[1][j]) - C_E_W'(r_p[0][j]);
        end
    end

    assign w_lhs = TW'(r_det[C_DET_W-2:0]) << C_THR_W;
    assign w_rhs = TW'(r_thr) << THR_SH;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rev     <= i_reverse_order;
            r_p[0][0] <= i_p0_x;
            r_p[0][1] <= i_p0_y;
            r_p[0][2] <= i_p0_z;
            r_p[1][0] <= i_p1_x;
            r_p[1][1] <= i_p1_y;
            r_p[1][2] <= i_p1_z;
            r_p[2][0] <= i_p2_x;
            r_p[2][1] <= i_p2_y;
            r_p[2][2] <= i_p2_z;
            for (int j = 0; j < 3; j++) begin
                r_u[j]       <= n_u[j];
                r_w[j]       <= n_w[j];
                r_p0[j]      <= r_p[0][j];
                r_u_d[0][j]  <= r_u[j];
                r_w_d[0][j]  <= r_w[j];
                r_p0_d[0][j] <= r_p0[j];
                for (int i = 1; i < UW_D; i++) begin
                    r_u_d[i][j] <= r_u_d[i-1][j];
                    r_w_d[i][j] <= r_w_d[i-1][j];
                end
                for (int i = 1; i < P0_D; i++) r_p0_d[i][j] <= r_p0_d[i-1][j];
                r_sn[j]      <= C_N_W'(w_du[j]) - C_N_W'(w_bw[j]);
                r_tn[j]      <= C_N_W'(w_bu[j]) - C_N_W'(w_aw[j]);
                r_sn_d[0][j] <= r_sn[j];
                r_tn_d[0][j] <= r_tn[j];
                for (int i = 1; i < SN_D; i++) begin
                    r_sn_d[i][j] <= r_sn_d[i-1][j];
                    r_tn_d[i][j] <= r_tn_d[i-1][j];
                end
            end
            r_a <= C_G_W'(w_uu[0]) + C_G_W'(w_uu[1]) + C_G_W'(w_uu[2]);
            r_b <= C_G_W'(w_uw[0]) + C_G_W'(w_uw[1]) + C_G_W'(w_uw[2]);
            r_d <= C_G_W'(w_ww[0]) + C_G_W'(w_ww[1]) + C_G_W'(w_ww[2]);
            r_det      <= w_ad - w_bb;
            r_det_d[0] <= r_det;
            for (int i = 1; i < SN_D; i++) r_det_d[i] <= r_det_d[i-1];
            // the determinant is never negative, so its magnitude is its value
            r_deg      <= (r_det == '0) || (w_lhs < w_rhs);
            r_deg_d[0] <= r_deg;
            for (int i = 1; i < DG_D; i++) r_deg_d[i] <= r_deg_d[i-1];
            r_so <= -(C_O_W'(w_sp[0]) + C_O_W'(w_sp[1]) + C_O_W'(w_sp[2]));
            r_to <= -(C_O_W'(w_tp[0]) + C_O_W'(w_tp[1]) + C_O_W'(w_tp[2]));
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_axis
        tpa_mul #(.WA(C_E_W), .WB(C_E_W)) u_mul_uu (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_u[j]), .i_b(r_u[j]), .o_p(w_uu[j])
        );
        tpa_mul #(.WA(C_E_W), .WB(C_E_W)) u_mul_uw (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_u[j]), .i_b(r_w[j]), .o_p(w_uw[j])
        );
        tpa_mul #(.WA(C_E_W), .WB(C_E_W)) u_mul_ww (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_w[j]), .i_b(r_w[j]), .o_p(w_ww[j])
        );
        tpa_mul #(.WA(C_G_W), .WB(C_E_W)) u_mul_du (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_d), .i_b(r_u_d[UW_D-1][j]), .o_p(w_du[j])
        );
        tpa_mul #(.WA(C_G_W), .WB(C_E_W)) u_mul_bw (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_b), .i_b(r_w_d[UW_D-1][j]), .o_p(w_bw[j])
        );
        tpa_mul #(.WA(C_G_W), .WB(C_E_W)) u_mul_bu (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_b), .i_b(r_u_d[UW_D-1][j]), .o_p(w_bu[j])
        );
        tpa_mul #(.WA(C_G_W), .WB(C_E_W)) u_mul_aw (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_a), .i_b(r_w_d[UW_D-1][j]), .o_p(w_aw[j])
        );
        tpa_mul #(.WA(C_N_W), .WB(C_IN_W)) u_mul_sp (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_sn[j]), .i_b(r_p0_d[P0_D-1][j]), .o_p(w_sp[j])
        );
        tpa_mul #(.WA(C_N_W), .WB(C_IN_W)) u_mul_tp (
            .i_clk(i_clk), .i_en(w_adv), .i_a(r_tn[j]), .i_b(r_p0_d[P0_D-1][j]), .o_p(w_tp[j])
        );
        tpa_div #(.NUM_W(C_N_W), .DEN_W(DEN_W), .SH(SH_AX)) u_div_s (
            .i_clk(i_clk), .i_en(w_adv), .i_num(r_sn_d[SN_D-1][j]),
            .i_den(r_det_d[SN_D-1][DEN_W-1:0]), .o_q(w_sq[j])
        );
        tpa_div #(.NUM_W(C_N_W), .DEN_W(DEN_W), .SH(SH_AX)) u_div_t (
            .i_clk(i_clk), .i_en(w_adv), .i_num(r_tn_d[SN_D-1][j]),
            .i_den(r_det_d[SN_D-1][DEN_W-1:0]), .o_q(w_tq[j])
        );
    end

    tpa_mul #(.WA(C_G_W), .WB(C_G_W)) u_mul_ad (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_a), .i_b(r_d), .o_p(w_ad)
    );
    tpa_mul #(.WA(C_G_W), .WB(C_G_W)) u_mul_bb (
        .i_clk(i_clk), .i_en(w_adv), .i_a(r_b), .i_b(r_b), .o_p(w_bb)
    );

    tpa_div #(.NUM_W(C_O_W), .DEN_W(DEN_W), .SH(SH_OF)) u_div_so (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_so),
        .i_den(r_det_d[SN_D-1][DEN_W-1:0]), .o_q(w_soq)
    );
    tpa_div #(.NUM_W(C_O_W), .DEN_W(DEN_W), .SH(SH_OF)) u_div_to (
        .i_clk(i_clk), .i_en(w_adv), .i_num(r_to),
        .i_den(r_det_d[SN_D-1][DEN_W-1:0]), .o_q(w_toq)
    );

    always_comb begin
        n_res.degenerate = r_deg_d[DG_D-1];
        n_res.s_axis_x   = r_deg_d[DG_D-1] ? '0 : w_sq[0];
        n_res.s_axis_y   = r_deg_d[DG_D-1] ? '0 : w_sq[1];
        n_res.s_axis_z   = r_deg_d[DG_D-1] ? '0 : w_sq[2];
        n_res.s_offset   = r_deg_d[DG_D-1] ? '0 : w_soq;
        n_res.t_axis_x   = r_deg_d[DG_D-1] ? '0 : w_tq[0];
        n_res.t_axis_y   = r_deg_d[DG_D-1] ? '0 : w_tq[1];
        n_res.t_axis_z   = r_deg_d[DG_D-1] ? '0 : w_tq[2];
        n_res.t_offset   = r_deg_d[DG_D-1] ? '0 : w_toq;
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (w_push) r_fifo[r_wptr] <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop)  r_rptr <= !r_rptr;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign w_head       = r_fifo[r_rptr];
    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_s_axis_x   = w_head.s_axis_x;
    assign o_s_axis_y   = w_head.s_axis_y;
    assign o_s_axis_z   = w_head.s_axis_z;
    assign o_s_offset   = w_head.s_offset;
    assign o_t_axis_x   = w_head.t_axis_x;
    assign o_t_axis_y   = w_head.t_axis_y;
    assign o_t_axis_z   = w_head.t_axis_z;
    assign o_t_offset   = w_head.t_offset;
    assign o_degenerate = w_head.degenerate;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && r_cnt == 2'd2 && !w_pop))
        else $error("output queue written while full");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("accepted beat missing from first stage");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |->
            (o_s_axis_x == '0 && o_s_axis_y == '0 && o_s_axis_z == '0 && o_s_offset == '0 &&
             o_t_axis_x == '0 && o_t_axis_y == '0 && o_t_axis_z == '0 && o_t_offset == '0))
        else $error("degenerate beat with nonzero fields");

endmodule

// ----- sv/tpa_mul.sv -----
// pipelined signed multiplier built from 32x32 limb products
module tpa_mul import tpa_pkg::*; #(
    parameter int WA = 27,
    parameter int WB = 27
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);

    localparam int LW = C_LIMB_W;
    localparam int NA = (WA + LW - 1) / LW;
    localparam int NB = (WB + LW - 1) / LW;
    localparam int PW = (NA + NB) * LW;
    localparam int WP = WA + WB;

    logic [WA-1:0]     w_abs_a;
    logic [WB-1:0]     w_abs_b;
    logic [2:0]        r_sgn;
    logic [NA*LW-1:0]  r_ma;
    logic [NB*LW-1:0]  r_mb;
    logic [2*LW-1:0]   r_pp [NA][NB];
    logic [PW-1:0]     r_row [NA];
    logic [PW-1:0]     n_row [NA];
    logic [PW-1:0]     n_tot;
    logic [PW-1:0]     n_neg;
    logic [WP-1:0]     r_p;

    assign w_abs_a = i_a[WA-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[WB-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * LW));
            end
        end
        n_tot = '0;
        for (int i = 0; i < NA; i++) begin
            n_tot = n_tot + (r_row[i] << (i * LW));
        end
        n_neg = ~n_tot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn <= {r_sgn[1:0], i_a[WA-1] ^ i_b[WB-1]};
            r_ma  <= (NA*LW)'(w_abs_a);
            r_mb  <= (NB*LW)'(w_abs_b);
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[i*LW +: LW] * r_mb[j*LW +: LW];
                end
                r_row[i] <= n_row[i];
            end
            r_p <= r_sgn[2] ? n_neg[WP-1:0] : n_tot[WP-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ----- sv/tpa_div.sv -----
// pipelined rounding divider, one quotient bit per stage, saturated signed result
module tpa_div import tpa_pkg::*; #(
    parameter int NUM_W = 84,
    parameter int DEN_W = 111,
    parameter int SH    = 47
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [NUM_W-1:0]   i_num,
    input  logic        [DEN_W-1:0]   i_den,
    output logic signed [C_OUT_W-1:0] o_q
);

    localparam int QW = C_OUT_W;
    localparam int NW = NUM_W + SH;
    localparam int RW = ((NW > DEN_W + QW) ? NW : DEN_W + QW) + 1;

    logic [NUM_W-1:0] w_mag;
    logic             r_neg0;
    logic [NUM_W-1:0] r_mag;
    logic [DEN_W-1:0] r_den0;
    logic [RW-1:0]    r_rem [QW+1];
    logic [QW-1:0]    r_q   [QW+1];
    logic [DEN_W-1:0] r_den [QW+1];
    logic             r_neg [QW+1];
    logic             r_ovf [QW+1];
    logic [RW-1:0]    w_trial [QW];
    logic             w_ge    [QW];
    logic [RW-1:0]    n_rem   [QW];
    logic [QW-1:0]    n_q     [QW];
    logic             r_up;
    logic [QW-1:0]    r_q_f;
    logic             r_neg_f;
    logic             r_ovf_f;
    logic [QW:0]      n_qr;
    logic [QW:0]      n_lim;
    logic [QW:0]      n_qv;
    logic [QW-1:0]    r_out;

    assign w_mag = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;

    always_comb begin
        for (int s = 0; s < QW; s++) begin
            w_trial[s] = RW'(r_den[s]) << (QW - 1 - s);
            w_ge[s]    = r_rem[s] >= w_trial[s];
            n_rem[s]   = w_ge[s] ? r_rem[s] - w_trial[s] : r_rem[s];
            n_q[s]     = r_q[s];
            n_q[s][QW-1-s] = w_ge[s];
        end
    end

    // ties away from zero, then clamp to the signed range
    always_comb begin
        n_qr  = {1'b0, r_q_f} + (QW+1)'(r_up);
        n_lim = ((QW+1)'(1) << (QW - 1)) - (QW+1)'(!r_neg_f);
        n_qv  = (r_ovf_f || n_qr > n_lim) ? n_lim : n_qr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0   <= i_num[NUM_W-1];
            r_mag    <= w_mag;
            r_den0   <= i_den;
            r_rem[0] <= RW'(r_mag) << SH;
            r_ovf[0] <= (RW'(r_mag) << SH) >= (RW'(r_den0) << QW);
            r_q[0]   <= '0;
            r_den[0] <= r_den0;
            r_neg[0] <= r_neg0;
            for (int s = 0; s < QW; s++) begin
                r_rem[s+1] <= n_rem[s];
                r_q[s+1]   <= n_q[s];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
            r_up    <= {r_rem[QW], 1'b0} >= (RW+1)'(r_den[QW]);
            r_q_f   <= r_q[QW];
            r_neg_f <= r_neg[QW];
            r_ovf_f <= r_ovf[QW];
            r_out   <= r_neg_f ? QW'(~n_qv + 1'b1) : QW'(n_qv);
        end
    end

    assign o_q = r_out;

endmodule
